// ===== rtl/pmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmcd_pkg
// Shared types, constants and keyword tables of the PWM meter command decoder.
// ----------------------------------------------------------------------------
package pmcd_pkg;

  localparam int BUFFER_LENGTH  = 32;
  localparam int KW_COUNT       = 11;
  localparam int KW_MAX         = 11;
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CCR_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CCR_GAIN  = 1'd1;

  typedef enum logic [3:0] {
    CMD_GET       = 4'd0,
    CMD_SET       = 4'd1,
    CMD_INC       = 4'd2,
    CMD_DEC       = 4'd3,
    CMD_LAMP_ON   = 4'd4,
    CMD_LAMP_OFF  = 4'd5,
    CMD_LED_ON    = 4'd6,
    CMD_LED_OFF   = 4'd7,
    CMD_RELOAD    = 4'd8,
    CMD_PRESCALE  = 4'd9,
    CMD_COMPARE   = 4'd10,
    CMD_REJECT    = 4'd11
  } cmd_code_e;

  typedef struct packed {
    cmd_code_e          cmd_code;
    logic signed [23:0] speed_centi;
    logic [15:0]        compare_value;
    logic [15:0]        prescaler;
    logic [15:0]        reload;
    logic               light_out;
    logic               led_out;
  } result_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // keywords whose argument is a plain integer (ARR, PSC, CCR)
  localparam logic [KW_COUNT-1:0] KW_INT_MASK = 11'h700;

  // strings are right-justified: the last character sits in the low byte
  localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    "/get", "/set:", "/inc:", "/dec:", "/light_on;", "/light_off;",
    "/led_on;", "/led_off;", "/ARR:", "/PSC:", "/CCR:"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd5, 4'd5, 4'd10, 4'd11, 4'd8, 4'd9, 4'd5, 4'd5, 4'd5
  };

  // character of keyword k at position pos, valid for pos below its length
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
    logic [3:0] idx;
    idx = KW_LEN[k] - 4'd1 - pos;
    return KW_TEXT[k][{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/pmcd_rx_if.sv =====
// ----------------------------------------------------------------------------
// pmcd_rx_if / pmcd_res_if
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface pmcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmcd_res_if;
  import pmcd_pkg::*;

  logic               valid;
  logic               ready;
  cmd_code_e          cmd_code;
  logic signed [23:0] speed_centi;
  logic [15:0]        compare_value;
  logic [15:0]        prescaler;
  logic [15:0]        reload;
  logic               light_out;
  logic               led_out;

  modport source (
    output valid, output cmd_code, output speed_centi, output compare_value,
    output prescaler, output reload, output light_out, output led_out,
    input ready
  );
  modport sink (
    input valid, input cmd_code, input speed_centi, input compare_value,
    input prescaler, input reload, input light_out, input led_out,
    output ready
  );
endinterface

// ===== rtl/pwm_meter_command_decoder.sv =====
// ----------------------------------------------------------------------------
// pwm_meter_command_decoder
// Parses '/'-framed serial commands and keeps speed, timer and output state.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; rx ready drops only while four results are
// in flight in the three execute stages and the output queue together.
// Path: the result of the ';' (or overflowing) byte passes the three execute
// stages (magnitude scale, speed update, compare multiply) and the output queue.
// Reset: asynchronous, clears the parser, all stores, config and the queue.
module pwm_meter_command_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pmcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pmcd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  pmcd_rx_if.sink                           rx_i,
  pmcd_res_if.source                        res_o
);
  import pmcd_pkg::*;

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [5:0] BUF_LEN = 6'(BUFFER_LENGTH);
  localparam logic [5:0] NUM_START = 6'd5;

  // config
  logic [15:0] ccr_start_q;
  logic [23:0] ccr_gain_q;

  // parser state
  logic                collecting_q, collecting_d;
  logic [5:0]          position_q, position_d;
  logic [KW_COUNT-1:0] kw_match_q, kw_match_d;
  logic [31:0]         num_acc_q, num_acc_d;
  logic                num_neg_q, num_neg_d;
  logic [1:0]          num_phase_q, num_phase_d;
  logic [1:0]          frac_cnt_q, frac_cnt_d;

  // stores
  logic signed [23:0] speed_q, speed_d;
  logic [15:0]        compare_q, compare_d;
  logic [15:0]        prescaler_q, prescaler_d;
  logic [15:0]        reload_q, reload_d;
  logic               light_q, light_d;
  logic               led_q, led_d;

  // execute stages
  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  cmd_code_e          s1_code_q, s2_code_q, s3_code_q;
  logic [31:0]        s1_acc_q;
  logic [1:0]         s1_frac_q;
  logic               s1_neg_q;
  logic [15:0]        s1_ival_q, s2_ival_q, s3_ival_q;
  logic signed [25:0] s2_sv_q;

  // result queue
  result_t              res_mem [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic [RES_CNT_W-1:0] inflight;
  logic                 res_push, res_pop;

  logic       rx_accept;
  logic [7:0] c;
  logic       emit;
  cmd_code_e  emit_code;
  logic       int_mode;
  logic       is_digit;
  logic [35:0] acc_mul;
  logic [31:0] acc_step;
  logic [15:0] ival_new;

  assign inflight = RES_CNT_W'(s1_valid_q) + RES_CNT_W'(s2_valid_q)
                  + RES_CNT_W'(s3_valid_q) + res_cnt_q;
  assign rx_i.ready = inflight < RES_CNT_W'(RES_FIFO_DEPTH);
  assign rx_accept  = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;
  assign is_digit   = c inside {[CH_ZERO:CH_NINE]};

  // next accumulator value for one more digit
  assign acc_mul  = {num_acc_q, 3'b000} + {3'b000, num_acc_q, 1'b0} + {32'd0, c[3:0]};

  always_comb begin
    if (int_mode) begin
      acc_step = acc_mul[31:0];
    end else if (acc_mul > 36'h07FFFFFFF) begin
      acc_step = 32'h7FFFFFFF;
    end else begin
      acc_step = acc_mul[31:0];
    end
  end

  // ---------------------------------------------------------------- parser
  always_comb begin
    collecting_d = collecting_q;
    position_d   = position_q;
    kw_match_d   = kw_match_q;
    num_acc_d    = num_acc_q;
    num_neg_d    = num_neg_q;
    num_phase_d  = num_phase_q;
    frac_cnt_d   = frac_cnt_q;
    emit         = 1'b0;
    emit_code    = CMD_REJECT;
    if (rx_accept) begin
      if (c == CH_SLASH) begin
        collecting_d = 1'b1;
        position_d   = '0;
        kw_match_d   = '1;
        num_acc_d    = '0;
        num_neg_d    = 1'b0;
        num_phase_d  = PH_SKIP;
        frac_cnt_d   = '0;
      end
      if (collecting_d) begin
        if (position_d >= BUF_LEN) begin
          collecting_d = 1'b0;
          emit         = 1'b1;
        end else begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if ({2'b00, KW_LEN[k]} > position_d) begin
              if (kw_char(k, position_d[3:0]) != c) begin
                kw_match_d[k] = 1'b0;
              end
            end
          end
          if (position_d >= NUM_START) begin
            case (num_phase_q)
              PH_SKIP: begin
                if (c == CH_SPACE || (c inside {[CH_TAB:CH_CR]})) begin
                  num_phase_d = PH_SKIP;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                  num_neg_d   = (c == CH_MINUS);
                  num_phase_d = PH_INT;
                end else if (is_digit) begin
                  num_acc_d   = {28'd0, c[3:0]};
                  num_phase_d = PH_INT;
                end else if (c == CH_DOT && !int_mode) begin
                  num_phase_d = PH_FRAC;
                end else begin
                  num_phase_d = PH_DONE;
                end
              end
              PH_INT: begin
                if (is_digit) begin
                  num_acc_d = acc_step;
                end else if (c == CH_DOT && !int_mode) begin
                  num_phase_d = PH_FRAC;
                end else begin
                  num_phase_d = PH_DONE;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (frac_cnt_q < 2'd2) begin
                    num_acc_d  = acc_step;
                    frac_cnt_d = frac_cnt_q + 2'd1;
                  end
                end else begin
                  num_phase_d = PH_DONE;
                end
              end
              default: begin
                num_phase_d = PH_DONE;
              end
            endcase
          end
          position_d = position_d + 6'd1;
          if (c == CH_SEMI) begin
            collecting_d = 1'b0;
            emit         = 1'b1;
            // lowest matching keyword that fits in the command length wins
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
              if (kw_match_d[k] && ({2'b00, KW_LEN[k]} <= position_d)) begin
                emit_code = cmd_code_e'(4'(k));
              end
            end
          end
        end
      end
    end
  end

  // integer mode follows the match bits, which no longer change past the ':'
  assign int_mode = |(kw_match_q & KW_INT_MASK);
  assign ival_new = num_neg_d ? (16'd0 - num_acc_d[15:0]) : num_acc_d[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      position_q   <= '0;
      kw_match_q   <= '1;
      num_acc_q    <= '0;
      num_neg_q    <= 1'b0;
      num_phase_q  <= PH_SKIP;
      frac_cnt_q   <= '0;
    end else begin
      collecting_q <= collecting_d;
      position_q   <= position_d;
      kw_match_q   <= kw_match_d;
      num_acc_q    <= num_acc_d;
      num_neg_q    <= num_neg_d;
      num_phase_q  <= num_phase_d;
      frac_cnt_q   <= frac_cnt_d;
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccr_start_q <= '0;
      ccr_gain_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CCR_START: ccr_start_q <= cfg_wdata_i[15:0];
        CFG_CCR_GAIN:  ccr_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------- stage 1: speed magnitude
  logic [38:0]        mag_full;
  logic [24:0]        mag_cap;
  logic signed [25:0] sv_mag;
  logic signed [25:0] sv_d;

  always_comb begin
    case (s1_frac_q)
      2'd0:    mag_full = {7'd0, s1_acc_q} * 39'd100;
      2'd1:    mag_full = {7'd0, s1_acc_q} * 39'd10;
      default: mag_full = {7'd0, s1_acc_q};
    endcase
    mag_cap = (mag_full > 39'h1000000) ? 25'h1000000 : mag_full[24:0];
    sv_mag  = $signed({1'b0, mag_cap});
    sv_d    = s1_neg_q ? -sv_mag : sv_mag;
  end

  // ------------------------------------------- stage 2: speed update
  logic signed [26:0] speed_sum;

  always_comb begin
    case (s2_code_q)
      CMD_SET: speed_sum = {s2_sv_q[25], s2_sv_q};
      CMD_INC: speed_sum = {{3{speed_q[23]}}, speed_q} + {s2_sv_q[25], s2_sv_q};
      CMD_DEC: speed_sum = {{3{speed_q[23]}}, speed_q} - {s2_sv_q[25], s2_sv_q};
      default: speed_sum = {{3{speed_q[23]}}, speed_q};
    endcase
    if (speed_sum > 27'sd8388607) begin
      speed_d = 24'sh7FFFFF;
    end else if (speed_sum < -27'sd8388608) begin
      speed_d = 24'sh800000;
    end else begin
      speed_d = speed_sum[23:0];
    end
  end

  // ------------------------------------------- stage 3: compare and stores
  logic signed [48:0] ccr_prod;
  logic signed [48:0] ccr_sum;
  logic [15:0]        ccr_calc;

  assign ccr_prod = $signed({1'b0, ccr_gain_q}) * speed_q;
  assign ccr_sum  = ccr_prod + $signed({17'd0, ccr_start_q, 16'd0});

  always_comb begin
    if (ccr_sum[48]) begin
      ccr_calc = 16'd0;
    end else if (ccr_sum[47:32] != 16'd0) begin
      ccr_calc = 16'hFFFF;
    end else begin
      ccr_calc = ccr_sum[31:16];
    end
  end

  always_comb begin
    compare_d   = compare_q;
    prescaler_d = prescaler_q;
    reload_d    = reload_q;
    light_d     = light_q;
    led_d       = led_q;
    if (s3_valid_q) begin
      case (s3_code_q)
        CMD_SET, CMD_INC, CMD_DEC: compare_d = ccr_calc;
        CMD_LAMP_ON:   light_d     = 1'b1;
        CMD_LAMP_OFF:  light_d     = 1'b0;
        CMD_LED_ON:    led_d       = 1'b1;
        CMD_LED_OFF:   led_d       = 1'b0;
        CMD_RELOAD:    reload_d    = s3_ival_q;
        CMD_PRESCALE:  prescaler_d = s3_ival_q;
        CMD_COMPARE:   compare_d   = s3_ival_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      speed_q     <= '0;
      compare_q   <= '0;
      prescaler_q <= '0;
      reload_q    <= '0;
      light_q     <= 1'b0;
      led_q       <= 1'b0;
    end else begin
      s1_valid_q <= emit;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s2_valid_q && (s2_code_q inside {CMD_SET, CMD_INC, CMD_DEC})) begin
        speed_q <= speed_d;
      end
      compare_q   <= compare_d;
      prescaler_q <= prescaler_d;
      reload_q    <= reload_d;
      light_q     <= light_d;
      led_q       <= led_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_code_q <= emit_code;
      s1_acc_q  <= num_acc_d;
      s1_frac_q <= frac_cnt_d;
      s1_neg_q  <= num_neg_d;
      s1_ival_q <= ival_new;
    end
    s2_code_q <= s1_code_q;
    s2_sv_q   <= sv_d;
    s2_ival_q <= s1_ival_q;
    s3_code_q <= s2_code_q;
    s3_ival_q <= s2_ival_q;
  end

  // ---------------------------------------------------------------- result queue
  result_t res_new;

  always_comb begin
    res_new.cmd_code      = s3_code_q;
    res_new.speed_centi   = speed_q;
    res_new.compare_value = compare_d;
    res_new.prescaler     = prescaler_d;
    res_new.reload        = reload_d;
    res_new.light_out     = light_d;
    res_new.led_out       = led_d;
  end

  assign res_push = s3_valid_q;
  assign res_pop  = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
      end
      if (res_pop) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
      case ({res_push, res_pop})
        2'b10:   res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
        2'b01:   res_cnt_q <= res_cnt_q - RES_CNT_W'(1);
        default: res_cnt_q <= res_cnt_q;
      endcase
    end
  end

  assign res_o.valid         = res_cnt_q != '0;
  assign res_o.cmd_code      = res_mem[rd_ptr_q].cmd_code;
  assign res_o.speed_centi   = res_mem[rd_ptr_q].speed_centi;
  assign res_o.compare_value = res_mem[rd_ptr_q].compare_value;
  assign res_o.prescaler     = res_mem[rd_ptr_q].prescaler;
  assign res_o.reload        = res_mem[rd_ptr_q].reload;
  assign res_o.light_out     = res_mem[rd_ptr_q].light_out;
  assign res_o.led_out       = res_mem[rd_ptr_q].led_out;

  // ---------------------------------------------------------------- checks
  // two commands never finish on adjacent bytes, so the stages never collide
  a_no_adjacent_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s2_valid_q) && !(s2_valid_q && s3_valid_q))
    else $error("execute stages hold adjacent transactions");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_cnt_q < RES_CNT_W'(RES_FIFO_DEPTH)) || res_pop)
    else $error("result queue overflow");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("more results in flight than queue slots");

  a_emit_stops_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !collecting_q && s1_valid_q)
    else $error("result issued while still collecting");

endmodule
